// ===== rtl/core/sse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SORT   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What every cell of the chain does in a given cycle.
    typedef enum logic [2:0] {
        CK_HOLD,
        CK_PUSH,
        CK_POP,
        CK_CLEAR,
        CK_SCAN,
        CK_CLOSE,
        CK_SORT
    } t_cell_kind;

    typedef struct packed {
        t_cell_kind               kind;
        logic signed [WORD_W-1:0] key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/sse_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sse_in_if;
    logic                              valid;
    logic                              ready;
    logic [sse_pkg::OP_W-1:0]          op;
    logic signed [sse_pkg::WORD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sse_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sse_pkg::WORD_W-1:0] pop_value;
    logic                              found;
    logic [sse_pkg::STATUS_W-1:0]      status;
    logic [sse_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output pop_value, output found, output status,
                    output count, input ready);
    modport sink   (input valid, input pop_value, input found, input status,
                    input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sse_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sse_cell (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire sse_pkg::t_cell_ctl            i_ctl,
    input  wire                                i_valid,
    input  wire                                i_pair_up,
    input  wire                                i_pair_dn,
    input  wire logic signed [sse_pkg::WORD_W-1:0] i_above,
    input  wire logic signed [sse_pkg::WORD_W-1:0] i_below,
    input  wire                                i_del_prev,
    output logic signed [sse_pkg::WORD_W-1:0]  o_value,
    output logic                               o_del
);

    logic signed [sse_pkg::WORD_W-1:0] r_value;
    logic signed [sse_pkg::WORD_W-1:0] n_value;
    logic                              r_del;
    logic                              n_del;

    always_comb begin
        n_value = r_value;
        n_del   = r_del;
        case (i_ctl.kind)
            sse_pkg::CK_PUSH:  n_value = i_above;
            sse_pkg::CK_POP:   n_value = i_below;
            sse_pkg::CK_CLEAR: n_del = 1'b0;
            // The delete mark spreads one cell toward the bottom each cycle.
            sse_pkg::CK_SCAN:  n_del = i_del_prev | (i_valid && (r_value == i_ctl.key));
            sse_pkg::CK_CLOSE: begin
                if (r_del) begin
                    n_value = i_below;
                end
            end
            // Upper cell of a pair keeps the larger word, lower cell the smaller.
            sse_pkg::CK_SORT: begin
                if (i_pair_up && (r_value < i_below)) begin
                    n_value = i_below;
                end else if (i_pair_dn && (i_above < r_value)) begin
                    n_value = i_above;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_del <= 1'b0;
        end else begin
            r_del <= n_del;
        end
    end

    assign o_value = r_value;
    assign o_del   = r_del;

endmodule

`default_nettype wire

// ===== rtl/core/sortable_stack_engine.sv =====
// Push and pop: a beat is accepted and its result is valid on the next cycle.
// Remove: the match mark sweeps the cell chain, then the gap is closed and the
// result loaded once the output is free. Sort: DEPTH odd-even transposition phases,
// then the result is loaded once the output is free. One operation at a time:
// push and pop take a beat every cycle while the output is free, remove and sort
// none until their result is loaded. Synchronous active-low reset empties the stack.
`timescale 1ns / 1ps
`default_nettype none

module sortable_stack_engine #(
    parameter int unsigned DEPTH = sse_pkg::DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sse_in_if.sink      i_cmd,
    sse_out_if.source   o_rsp
);

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned STEP_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLOSE,
        S_SORT,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic [FILL_W-1:0]                  r_fill;
    logic [FILL_W-1:0]                  n_fill;
    logic [STEP_W-1:0]                  r_step;
    logic signed [sse_pkg::WORD_W-1:0]  r_key;
    logic                               r_out_valid;
    logic signed [sse_pkg::WORD_W-1:0]  r_pop_value;
    logic                               r_found;
    logic [sse_pkg::STATUS_W-1:0]       r_status;
    logic [sse_pkg::COUNT_W-1:0]        r_count;

    sse_pkg::t_cell_ctl                 w_ctl;
    sse_pkg::t_op                       w_op;
    logic                               w_out_free;
    logic                               w_take;
    logic                               w_load;
    logic                               w_empty;
    logic                               w_full;
    logic                               w_last;
    logic                               w_found;

    logic signed [sse_pkg::WORD_W-1:0]  w_value [DEPTH];
    logic [DEPTH-1:0]                   w_del;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE) && w_out_free;
    assign w_take      = i_cmd.valid && i_cmd.ready;
    assign w_op        = sse_pkg::t_op'(i_cmd.op);
    assign w_empty     = (r_fill == '0);
    assign w_full      = (r_fill == FILL_W'(DEPTH));
    assign w_last      = (r_step == STEP_W'(DEPTH - 1));
    assign w_found     = w_del[DEPTH-1];

    // A result beat is loaded into the output register in this cycle.
    assign w_load = ((r_state == S_IDLE) && w_take
                        && ((w_op == sse_pkg::OP_PUSH) || (w_op == sse_pkg::OP_POP)))
                    || (((r_state == S_CLOSE) || (r_state == S_DONE)) && w_out_free);

    always_comb begin
        w_ctl.kind = sse_pkg::CK_HOLD;
        w_ctl.key  = r_key;
        n_fill     = r_fill;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (w_op)
                        sse_pkg::OP_PUSH: begin
                            if (!w_full) begin
                                w_ctl.kind = sse_pkg::CK_PUSH;
                                n_fill     = r_fill + 1'b1;
                            end
                        end
                        sse_pkg::OP_POP: begin
                            if (!w_empty) begin
                                w_ctl.kind = sse_pkg::CK_POP;
                                n_fill     = r_fill - 1'b1;
                            end
                        end
                        sse_pkg::OP_REMOVE: w_ctl.kind = sse_pkg::CK_CLEAR;
                        default:            w_ctl.kind = sse_pkg::CK_HOLD;
                    endcase
                end
            end
            S_SCAN: w_ctl.kind = sse_pkg::CK_SCAN;
            S_CLOSE: begin
                if (w_out_free && w_found) begin
                    w_ctl.kind = sse_pkg::CK_CLOSE;
                    n_fill     = r_fill - 1'b1;
                end
            end
            S_SORT: w_ctl.kind = sse_pkg::CK_SORT;
            default: w_ctl.kind = sse_pkg::CK_HOLD;
        endcase
    end

    // Cell 0 holds the top of the stack; cell DEPTH-1 the deepest slot.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                              w_valid;
        logic                              w_pair_up;
        logic                              w_pair_dn;
        logic signed [sse_pkg::WORD_W-1:0] w_above;
        logic signed [sse_pkg::WORD_W-1:0] w_below;
        logic                              w_del_prev;

        assign w_valid = (FILL_W'(gi) < r_fill);

        if (gi == 0) begin : g_top
            assign w_above    = i_cmd.value;
            assign w_del_prev = 1'b0;
            assign w_pair_dn  = 1'b0;
        end else begin : g_mid_up
            assign w_above    = w_value[gi-1];
            assign w_del_prev = w_del[gi-1];
            assign w_pair_dn  = (1'((gi - 1) % 2) == r_step[0]) && w_valid;
        end

        if (gi == DEPTH - 1) begin : g_bottom
            assign w_below   = '0;
            assign w_pair_up = 1'b0;
        end else begin : g_mid_dn
            assign w_below   = w_value[gi+1];
            assign w_pair_up = (1'(gi % 2) == r_step[0]) && (FILL_W'(gi + 1) < r_fill);
        end

        sse_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_valid    (w_valid),
            .i_pair_up  (w_pair_up),
            .i_pair_dn  (w_pair_dn),
            .i_above    (w_above),
            .i_below    (w_below),
            .i_del_prev (w_del_prev),
            .o_value    (w_value[gi]),
            .o_del      (w_del[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_key  <= i_cmd.value;
                        r_step <= '0;
                        unique case (w_op)
                            sse_pkg::OP_PUSH: begin
                                r_pop_value <= '0;
                                r_found     <= 1'b0;
                                r_status    <= w_full ? sse_pkg::ST_FULL : sse_pkg::ST_OK;
                                r_count     <= sse_pkg::COUNT_W'(n_fill);
                            end
                            sse_pkg::OP_POP: begin
                                r_pop_value <= w_empty ? '0 : w_value[0];
                                r_found     <= 1'b0;
                                r_status    <= w_empty ? sse_pkg::ST_EMPTY : sse_pkg::ST_OK;
                                r_count     <= sse_pkg::COUNT_W'(n_fill);
                            end
                            sse_pkg::OP_REMOVE: r_state <= S_SCAN;
                            default:            r_state <= S_SORT;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_step  <= '0;
                        r_state <= S_CLOSE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_CLOSE: begin
                    if (w_out_free) begin
                        r_pop_value <= '0;
                        r_found     <= w_found;
                        r_status    <= sse_pkg::ST_OK;
                        r_count     <= sse_pkg::COUNT_W'(n_fill);
                        r_state     <= S_IDLE;
                    end
                end
                S_SORT: begin
                    if (w_last) begin
                        r_step  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_pop_value <= '0;
                        r_found     <= 1'b0;
                        r_status    <= sse_pkg::ST_OK;
                        r_count     <= sse_pkg::COUNT_W'(n_fill);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.pop_value = r_pop_value;
    assign o_rsp.found     = r_found;
    assign o_rsp.status    = r_status;
    assign o_rsp.count     = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/sse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sse_checker (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    input  wire                                    i_in_ready,
    input  wire [sse_pkg::OP_W-1:0]                i_in_op,
    input  wire                                    i_out_valid,
    input  wire                                    i_out_ready,
    input  wire logic signed [sse_pkg::WORD_W-1:0] i_out_pop_value,
    input  wire                                    i_out_found,
    input  wire [sse_pkg::STATUS_W-1:0]            i_out_status,
    input  wire [sse_pkg::COUNT_W-1:0]             i_out_count
);

    // A result beat is held until the sink takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pop_value)
            && $stable(i_out_found) && $stable(i_out_status) && $stable(i_out_count))
        else $error("result beat changed while stalled");

    // A push or pop result is valid in the cycle after the command is accepted.
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready
            && (i_in_op == sse_pkg::OP_PUSH || i_in_op == sse_pkg::OP_POP)
        |=> i_out_valid && !i_out_found)
        else $error("push or pop result missing on the next cycle");

    // An error status never comes with a popped word or a removal.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != sse_pkg::ST_OK)
        |-> (i_out_pop_value == '0) && !i_out_found)
        else $error("error status carries data");

    // An empty pop leaves nothing held: the count reported with ST_EMPTY is zero.
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == sse_pkg::ST_EMPTY) |-> (i_out_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind sortable_stack_engine sse_checker u_sse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cmd.valid),
    .i_in_ready      (i_cmd.ready),
    .i_in_op         (i_cmd.op),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_pop_value (o_rsp.pop_value),
    .i_out_found     (o_rsp.found),
    .i_out_status    (o_rsp.status),
    .i_out_count     (o_rsp.count)
);

`default_nettype wire

// ===== dv/tb_sortable_stack_engine.sv =====
`timescale 1ns / 1ps

module tb_sortable_stack_engine;

    localparam int unsigned DEPTH = sse_pkg::DEPTH_DEF;
    localparam int unsigned RANDOM_BLOCKS = 14;
    localparam int unsigned BLOCK_BEATS = 100;

    typedef logic signed [sse_pkg::WORD_W-1:0] t_word;

    typedef struct packed {
        t_word                         pop_value;
        logic                          found;
        logic [sse_pkg::STATUS_W-1:0]  status;
        logic [sse_pkg::COUNT_W-1:0]   count;
    } t_stack_rsp;

    // Tracks the stack contents beat by beat and holds the responses still owed.
    class stack_scoreboard;
        t_word           words[DEPTH];
        int unsigned     fill;
        t_stack_rsp      rsp_q[$];
        int unsigned     errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return rsp_q.size();
        endfunction

        function void note_command(sse_pkg::t_op op, t_word value);
            t_stack_rsp  rsp;
            t_word       key;
            int          j;
            bit          hit;
            rsp = '0;
            case (op)
                sse_pkg::OP_PUSH: begin
                    if (fill >= DEPTH) begin
                        rsp.status = sse_pkg::ST_FULL;
                    end else begin
                        words[fill] = value;
                        fill++;
                    end
                end
                sse_pkg::OP_POP: begin
                    if (fill == 0) begin
                        rsp.status = sse_pkg::ST_EMPTY;
                    end else begin
                        fill--;
                        rsp.pop_value = words[fill];
                    end
                end
                sse_pkg::OP_REMOVE: begin
                    hit = 1'b0;
                    for (int i = int'(fill) - 1; i >= 0 && !hit; i--) begin
                        if (words[i] == value) begin
                            hit = 1'b1;
                            for (int k = i; k + 1 < int'(fill); k++) begin
                                words[k] = words[k + 1];
                            end
                            fill--;
                        end
                    end
                    rsp.found = hit;
                end
                default: begin
                    // Ascending from the bottom; equal words are interchangeable.
                    for (int i = 1; i < int'(fill); i++) begin
                        key = words[i];
                        j = i;
                        while (j > 0 && key < words[j - 1]) begin
                            words[j] = words[j - 1];
                            j--;
                        end
                        words[j] = key;
                    end
                end
            endcase
            rsp.count = fill[sse_pkg::COUNT_W-1:0];
            rsp_q.push_back(rsp);
        endfunction

        function void check_response(t_word pop_value, logic found,
                                     logic [sse_pkg::STATUS_W-1:0] status,
                                     logic [sse_pkg::COUNT_W-1:0] count);
            t_stack_rsp exp_rsp;
            if (rsp_q.size() == 0) begin
                $error("response beat with no command outstanding");
                errors++;
                return;
            end
            exp_rsp = rsp_q.pop_front();
            if (pop_value !== exp_rsp.pop_value) begin
                $error("pop_value: expected %0d, got %0d", exp_rsp.pop_value, pop_value);
                errors++;
            end
            if (found !== exp_rsp.found) begin
                $error("found: expected %0d, got %0d", exp_rsp.found, found);
                errors++;
            end
            if (status !== exp_rsp.status) begin
                $error("status: expected %0d, got %0d", exp_rsp.status, status);
                errors++;
            end
            if (count !== exp_rsp.count) begin
                $error("count: expected %0d, got %0d", exp_rsp.count, count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sse_in_if  cmd_if ();
    sse_out_if rsp_if ();

    stack_scoreboard sb = new();

    // Percent chance of a stall burst per beat; zero turns idling off.
    int unsigned idle_pct;

    sortable_stack_engine #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return 0;
            4, 5, 6: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_command(sse_pkg::t_op op, t_word value);
        cmd_if.valid = 1'b1;
        cmd_if.op    = op;
        cmd_if.value = value;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(op, value);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            cmd_if.valid = 1'b0;
            cmd_if.op    = sse_pkg::t_op'($urandom);
            cmd_if.value = $urandom;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    task automatic send_random(bit fill_heavy);
        int unsigned roll;
        t_word       value;
        roll  = $urandom_range(0, 99);
        value = pick_word();
        if (fill_heavy ? roll < 55 : roll < 20) begin
            send_command(sse_pkg::OP_PUSH, value);
        end else if (fill_heavy ? roll < 70 : roll < 65) begin
            send_command(sse_pkg::OP_POP, value);
        end else if (roll < 90) begin
            // Mostly aim at a word that is actually held so removals succeed.
            if (sb.fill > 0 && $urandom_range(0, 99) < 65) begin
                value = sb.words[$urandom_range(0, sb.fill - 1)];
            end
            send_command(sse_pkg::OP_REMOVE, value);
        end else begin
            send_command(sse_pkg::OP_SORT, value);
        end
    endtask

    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.pop_value, rsp_if.found, rsp_if.status,
                              rsp_if.count);
        end
    end

    initial begin
        t_word fill_words[15];
        fill_words = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 7, 7, -1, 1, 3, -5, 100,
                       32'sh8000_0000, 2, 7, 32'sh5555_5555, 32'shaaaa_aaaa};
        idle_pct     = 20;
        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.op    = sse_pkg::OP_PUSH;
        cmd_if.value = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty stack: pop, remove and sort all leave it untouched.
        send_command(sse_pkg::OP_POP, 0);
        send_command(sse_pkg::OP_REMOVE, 5);
        send_command(sse_pkg::OP_SORT, 0);
        send_command(sse_pkg::OP_PUSH, -1);
        send_command(sse_pkg::OP_SORT, 0);
        foreach (fill_words[i]) begin
            send_command(sse_pkg::OP_PUSH, fill_words[i]);
        end
        // The stack is full now, so this push must be refused.
        send_command(sse_pkg::OP_PUSH, 9);
        send_command(sse_pkg::OP_SORT, 0);
        send_command(sse_pkg::OP_REMOVE, 7);
        send_command(sse_pkg::OP_REMOVE, 12345);
        send_command(sse_pkg::OP_POP, 0);
        send_command(sse_pkg::OP_REMOVE, 32'sh8000_0000);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (blk >= RANDOM_BLOCKS - 2) begin
                idle_pct = 0;
            end
            for (int i = 0; i < BLOCK_BEATS; i++) begin
                send_random(((i / 25) % 2) == 0);
            end
        end
        cmd_if.valid = 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sse_pkg.sv
rtl/core/sse_if.sv
rtl/core/sse_cell.sv
rtl/core/sortable_stack_engine.sv
rtl/core/sse_checker.sv
dv/tb_sortable_stack_engine.sv
